// File: rtl/core/sha1md_pkg.sv
// shared types and constants for the sha-1 digest block
// no dependencies; imported by every module under rtl/core
`default_nettype none

package sha1md_pkg;

  typedef logic [31:0] word_t;
  typedef logic [4:0][31:0] chain_t;

  // initial hash values, word 0 in the lowest slice
  localparam chain_t H_INIT = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                               32'hefcdab89, 32'h67452301};

  // round constants, one per group of twenty rounds
  localparam logic [3:0][31:0] ROUND_K = {32'hca62c1d6, 32'h8f1bbcdc,
                                          32'h6ed9eba1, 32'h5a827999};

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] LAST_POS   = 6'd63;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [2:0] LAST_IDX   = 3'd4;

  typedef struct packed {
    logic       byte_en;
    logic       round_en;
    logic [7:0] data;
  } sched_ctrl_t;

  typedef struct packed {
    logic       load;
    logic       step;
    logic [1:0] phase;
  } round_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/sha1md_sched.sv
// message block buffer and schedule window in one 512-bit shift register
// bytes shift in eight bits at a time; during rounds it shifts a word and appends w[t+16]
// depends on sha1md_pkg
`default_nettype none

module sha1md_sched (
  input  wire logic                     clk,
  input  wire sha1md_pkg::sched_ctrl_t  ctrl,
  output      sha1md_pkg::word_t        w_top
);
  import sha1md_pkg::*;

  logic [511:0] win_r;
  logic [511:0] win_nxt;
  word_t        mix;
  word_t        w_new;

  // word j of the window sits at bits [511-32j -: 32] and holds w[t+j]
  assign w_top = win_r[511:480];
  assign mix   = win_r[95:64] ^ win_r[255:224] ^ win_r[447:416] ^ win_r[511:480];
  assign w_new = {mix[30:0], mix[31]};

  always_comb begin
    win_nxt = win_r;
    if (ctrl.byte_en) begin
      win_nxt = {win_r[503:0], ctrl.data};
    end else if (ctrl.round_en) begin
      win_nxt = {win_r[479:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/core/sha1md_round.sv
// sha-1 round unit: working variables a..e and one round per step
// depends on sha1md_pkg
`default_nettype none

module sha1md_round (
  input  wire logic                     clk,
  input  wire sha1md_pkg::round_ctrl_t  ctrl,
  input  wire sha1md_pkg::chain_t       chain,
  input  wire sha1md_pkg::word_t        w,
  output      sha1md_pkg::chain_t       vars
);
  import sha1md_pkg::*;

  chain_t vars_r;
  chain_t vars_nxt;
  word_t  a, b, c, d, e;
  word_t  f;
  word_t  tmp;

  assign a = vars_r[0];
  assign b = vars_r[1];
  assign c = vars_r[2];
  assign d = vars_r[3];
  assign e = vars_r[4];
  assign vars = vars_r;

  always_comb begin
    case (ctrl.phase)
      2'd0:    f = (b & c) | (~b & d);
      2'd2:    f = (b & c) | (b & d) | (c & d);
      default: f = b ^ c ^ d;
    endcase
  end

  assign tmp = {a[26:0], a[31:27]} + f + e + ROUND_K[ctrl.phase] + w;

  always_comb begin
    vars_nxt = vars_r;
    if (ctrl.load) begin
      vars_nxt = chain;
    end else if (ctrl.step) begin
      vars_nxt = {d, c, {b[1:0], b[31:2]}, a, tmp};
    end
  end

  always_ff @(posedge clk) begin
    vars_r <= vars_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/core/sha1_message_digest.sv
// sha-1 digest over a byte stream, five 32-bit digest words out per message
// depends on sha1md_pkg, sha1md_sched and sha1md_round
`default_nettype none

// A message byte is taken whenever in_tready is high. Each 64th byte starts
// a compression that holds in_tready low: 80 rounds through the single round
// unit, one round per cycle, and then the add state that folds the result
// into the chain. The word that ends a message then runs padding byte by
// byte through the block buffer: the 0x80 byte, zero bytes up to byte 56 of
// the block and the eight length bytes, with one compression, or two when
// fewer than nine bytes were left in the block. The five digest words then
// appear, word 0 first, one per accepted output cycle; the last carries
// out_tlast and the block then returns to its initial hash values for the
// next message.

module sha1_message_digest (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // msg_byte
  input  wire logic        in_tuser,   // byte_valid
  input  wire logic        in_tlast,   // end_of_message
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [31:0] out_tdata,  // digest_word
  output      logic [2:0]  out_tuser,  // word_index
  output      logic        out_tlast   // last_word
);
  import sha1md_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PAD80  = 3'd1;
  localparam logic [2:0] ST_PADZ   = 3'd2;
  localparam logic [2:0] ST_PADLEN = 3'd3;
  localparam logic [2:0] ST_ROUND  = 3'd4;
  localparam logic [2:0] ST_ADD    = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  logic [2:0]  state_r, state_nxt;
  logic [2:0]  ret_r, ret_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [6:0]  rnd_r, rnd_nxt;
  logic [60:0] count_r, count_nxt;
  logic [63:0] len_r, len_nxt;
  logic [2:0]  idx_r, idx_nxt;
  chain_t      chain_r, chain_nxt;
  chain_t      vars;
  word_t       w_top;
  sched_ctrl_t sc;
  round_ctrl_t rc;
  logic [2:0]  after_st;

  sha1md_sched u_sched (
    .clk   (clk),
    .ctrl  (sc),
    .w_top (w_top)
  );

  sha1md_round u_round (
    .clk   (clk),
    .ctrl  (rc),
    .chain (chain_r),
    .w     (w_top),
    .vars  (vars)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = chain_r[idx_r];
  assign out_tuser  = idx_r;
  assign out_tlast  = (idx_r == LAST_IDX);

  always_comb begin
    state_nxt   = state_r;
    ret_nxt     = ret_r;
    pos_nxt     = pos_r;
    rnd_nxt     = rnd_r;
    count_nxt   = count_r;
    len_nxt     = len_r;
    idx_nxt     = idx_r;
    chain_nxt   = chain_r;
    after_st    = ST_IDLE;
    sc.byte_en  = 1'b0;
    sc.round_en = 1'b0;
    sc.data     = in_tdata;
    rc.load     = 1'b0;
    rc.step     = 1'b0;
    if (rnd_r < 7'd20) begin
      rc.phase = 2'd0;
    end else if (rnd_r < 7'd40) begin
      rc.phase = 2'd1;
    end else if (rnd_r < 7'd60) begin
      rc.phase = 2'd2;
    end else begin
      rc.phase = 2'd3;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          after_st = in_tlast ? ST_PAD80 : ST_IDLE;
          if (in_tuser) begin
            sc.byte_en = 1'b1;
            pos_nxt    = pos_r + 6'd1;
            count_nxt  = count_r + 61'd1;
          end
          if (in_tuser && pos_r == LAST_POS) begin
            state_nxt = ST_ROUND;
            ret_nxt   = after_st;
            rc.load   = 1'b1;
            rnd_nxt   = '0;
          end else begin
            state_nxt = after_st;
          end
        end
      end
      ST_PAD80: begin
        len_nxt    = {count_r, 3'b000};
        sc.byte_en = 1'b1;
        sc.data    = PAD_BYTE;
        pos_nxt    = pos_r + 6'd1;
        state_nxt  = ST_PADZ;
        if (pos_r == LAST_POS) begin
          state_nxt = ST_ROUND;
          ret_nxt   = ST_PADZ;
          rc.load   = 1'b1;
          rnd_nxt   = '0;
        end
      end
      ST_PADZ: begin
        if (pos_r == LEN_POS) begin
          state_nxt = ST_PADLEN;
        end else begin
          sc.byte_en = 1'b1;
          sc.data    = 8'h00;
          pos_nxt    = pos_r + 6'd1;
          if (pos_r == LAST_POS) begin
            state_nxt = ST_ROUND;
            ret_nxt   = ST_PADZ;
            rc.load   = 1'b1;
            rnd_nxt   = '0;
          end
        end
      end
      ST_PADLEN: begin
        // bit length goes out high byte first
        sc.byte_en = 1'b1;
        sc.data    = len_r[63:56];
        len_nxt    = {len_r[55:0], 8'h00};
        pos_nxt    = pos_r + 6'd1;
        if (pos_r == LAST_POS) begin
          state_nxt = ST_ROUND;
          ret_nxt   = ST_OUT;
          rc.load   = 1'b1;
          rnd_nxt   = '0;
        end
      end
      ST_ROUND: begin
        rc.step     = 1'b1;
        sc.round_en = 1'b1;
        rnd_nxt     = rnd_r + 7'd1;
        if (rnd_r == LAST_ROUND) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        for (int i = 0; i < 5; i++) begin
          chain_nxt[i] = chain_r[i] + vars[i];
        end
        state_nxt = ret_r;
      end
      ST_OUT: begin
        if (out_tready) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == LAST_IDX) begin
            idx_nxt   = '0;
            chain_nxt = H_INIT;
            count_nxt = '0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= ST_IDLE;
      pos_r   <= '0;
      rnd_r   <= '0;
      count_r <= '0;
      idx_r   <= '0;
      chain_r <= H_INIT;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      pos_r   <= pos_nxt;
      rnd_r   <= rnd_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      chain_r <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
  end

endmodule

`default_nettype wire

// File: tb/tb_sha1_message_digest.sv
// self-checking testbench for sha1_message_digest: streams byte words, predicts each digest
// with its own sha-1 model and compares every digest word in order
// depends on sha1md_pkg and the sha1_message_digest rtl
`default_nettype none

module tb_sha1_message_digest;

  import sha1md_pkg::*;

  typedef struct {
    logic [31:0] digest;
    logic [2:0]  index;
    logic        last;
  } digest_entry_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  word_t       out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  // predictor state
  logic [31:0] hash_state [5];
  logic [7:0]  blk_bytes [64];
  logic [60:0] msg_len;

  digest_entry_t pending_digest[$];

  int error_count = 0;
  int item_count = 0;
  int tx_max = 14;
  int rx_max = 14;
  int stall_req = 0;

  sha1_message_digest uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // msg_byte
    .in_tuser  (in_tuser),   // byte_valid
    .in_tlast  (in_tlast),   // end_of_message
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // digest_word
    .out_tuser (out_tuser),  // word_index
    .out_tlast (out_tlast)   // last_word
  );

  always #10 clk = ~clk;

  function automatic logic [31:0] rol32(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void load_initial_hash();
    hash_state[0] = 32'h67452301;
    hash_state[1] = 32'hefcdab89;
    hash_state[2] = 32'h98badcfe;
    hash_state[3] = 32'h10325476;
    hash_state[4] = 32'hc3d2e1f0;
    msg_len = '0;
  endfunction

  function automatic void sha1_compress();
    logic [31:0] sched [16];
    logic [31:0] a, b, c, d, e, f, k, wt, tmp;
    for (int i = 0; i < 16; i++) begin
      sched[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    end
    a = hash_state[0];
    b = hash_state[1];
    c = hash_state[2];
    d = hash_state[3];
    e = hash_state[4];
    for (int t = 0; t < 80; t++) begin
      if (t < 16) begin
        wt = sched[t];
      end else begin
        wt = rol32(sched[(t+13)&15] ^ sched[(t+8)&15] ^ sched[(t+2)&15] ^ sched[t&15], 1);
        sched[t&15] = wt;
      end
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5a827999;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ed9eba1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8f1bbcdc;
      end else begin
        f = b ^ c ^ d;
        k = 32'hca62c1d6;
      end
      tmp = rol32(a, 5) + f + e + k + wt;
      e = d;
      d = c;
      c = rol32(b, 30);
      b = a;
      a = tmp;
    end
    hash_state[0] += a;
    hash_state[1] += b;
    hash_state[2] += c;
    hash_state[3] += d;
    hash_state[4] += e;
  endfunction

  // takes one accepted word and queues the digest words it finishes
  function automatic void sha1_absorb(logic [7:0] data, logic valid, logic last);
    logic [5:0]    pos;
    logic [63:0]   bit_len;
    digest_entry_t ent;
    if (valid) begin
      pos = msg_len[5:0];
      blk_bytes[pos] = data;
      msg_len = msg_len + 61'd1;
      if (pos == 6'd63) sha1_compress();
    end
    if (!last) return;
    pos = msg_len[5:0];
    blk_bytes[pos] = 8'h80;
    for (int i = pos + 1; i < 64; i++) blk_bytes[i] = 8'h00;
    // no room for the length: it goes into an extra block
    if (pos >= 6'd56) begin
      sha1_compress();
      for (int i = 0; i < 64; i++) blk_bytes[i] = 8'h00;
    end
    bit_len = {msg_len, 3'b000};
    for (int i = 0; i < 8; i++) blk_bytes[56+i] = bit_len[63-8*i -: 8];
    sha1_compress();
    for (int i = 0; i < 5; i++) begin
      ent.digest = hash_state[i];
      ent.index  = 3'(i);
      ent.last   = (i == 4);
      pending_digest.push_back(ent);
    end
    load_initial_hash();
  endfunction

  task automatic send_item(logic [7:0] data, logic valid, logic last);
    int gap;
    gap = (tx_max == 0) ? 0 : $urandom_range(0, tx_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= valid;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sha1_absorb(data, valid, last);
    item_count++;
  endtask

  // random content; the end marker rides on the last byte or on its own word
  task automatic send_message(int len, bit with_noise);
    bit separate_end;
    separate_end = (len == 0) || ($urandom_range(0, 2) == 0);
    for (int i = 0; i < len; i++) begin
      if (with_noise && $urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, !separate_end && (i == len - 1));
    end
    if (separate_end) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // the sender stops offering so an old word is not taken twice
  task automatic wait_digest_drain();
    in_tvalid <= 1'b0;
    while (pending_digest.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_edges();
    tx_max = 14;
    rx_max = 14;
    // empty message, data bits set but not valid
    send_item(8'hff, 1'b0, 1'b1);
    // ignored word, then a single zero byte
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h7f, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
  endtask

  // lengths around the point where padding needs a second block
  task automatic test_block_boundaries();
    tx_max = 0;
    rx_max = 0;
    send_message(55, 1'b0);
    send_message(56, 1'b0);
    tx_max = 14;
    rx_max = 14;
    send_message(63, 1'b0);
    send_message(64, 1'b0);
  endtask

  task automatic test_output_stall();
    wait_digest_drain();
    tx_max = 0;
    rx_max = 0;
    stall_req = 400;
    for (int m = 0; m < 4; m++) send_message(3, 1'b0);
  endtask

  task automatic test_random_messages();
    int pick;
    int len;
    while (item_count < 480) begin
      tx_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
      rx_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
      pick = $urandom_range(0, 9);
      if (pick < 7) len = $urandom_range(0, 20);
      else if (pick < 9) len = $urandom_range(21, 70);
      else len = $urandom_range(71, 130);
      if (len > 480 - item_count) len = 480 - item_count;
      send_message(len, 1'b1);
    end
  endtask

  // digest word receiver and checker
  initial begin
    int gap;
    digest_entry_t exp_word;
    @(posedge rst_n);
    forever begin
      gap = (rx_max == 0) ? 0 : $urandom_range(0, rx_max);
      gap += stall_req;
      stall_req = 0;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      if (pending_digest.size() == 0) begin
        $display("%0t unexpected digest word: expected none, actual %h idx %0d last %0b",
                 $time, out_tdata, out_tuser, out_tlast);
        error_count++;
      end else begin
        exp_word = pending_digest.pop_front();
        if (out_tdata !== exp_word.digest) begin
          $display("%0t digest_word mismatch: expected %h, actual %h",
                   $time, exp_word.digest, out_tdata);
          error_count++;
        end
        if (out_tuser !== exp_word.index) begin
          $display("%0t word_index mismatch: expected %0d, actual %0d",
                   $time, exp_word.index, out_tuser);
          error_count++;
        end
        if (out_tlast !== exp_word.last) begin
          $display("%0t last_word mismatch: expected %0b, actual %0b",
                   $time, exp_word.last, out_tlast);
          error_count++;
        end
      end
    end
  end

  initial begin
    load_initial_hash();
    for (int i = 0; i < 64; i++) blk_bytes[i] = 8'h00;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_edges();
    test_block_boundaries();
    test_output_stall();
    test_random_messages();
    wait_digest_drain();
    repeat (250) @(posedge clk);
    if (error_count == 0) begin
      $display("sha1_message_digest verification clean");
    end else begin
      $display("sha1_message_digest verification failed");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("sha1_message_digest verification failed");
    $finish;
  end

endmodule

`default_nettype wire
